>>> design/gdf_pkg.sv
// Shared types, sizes and register codes for the ghost detection filter.
// No dependencies; every other design file imports this package.
package gdf_pkg;

   localparam int HISTORY_FRAMES = 8;
   localparam int MAX_RECTS      = 16;

   localparam int SLOT_W  = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;
   localparam int IDX_W   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CNT_W   = $clog2(MAX_RECTS + 1);
   localparam int ADDR_W  = SLOT_W + IDX_W;
   localparam int MATCH_W = $clog2((HISTORY_FRAMES - 1) * MAX_RECTS + 1);

   localparam int COORD_W = 12;
   localparam int CTR_W   = 13;
   localparam int THR_W   = 12;
   localparam int HITS_W  = 8;
   localparam int WIN_W   = 4;
   localparam int TSQ_W   = 2 * THR_W;
   localparam int DSQ_W   = 2 * CTR_W;
   localparam int SUM_W   = DSQ_W + 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_DIST_THRESH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_HITS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_FRAMES = 2'd2;

   localparam logic [THR_W-1:0]  RST_DIST_THRESH   = 12'd20;
   localparam logic [HITS_W-1:0] RST_MIN_HITS      = 8'd3;
   localparam logic [WIN_W-1:0]  RST_WINDOW_FRAMES = 4'd5;

   localparam logic FUNC_RECT      = 1'b0;
   localparam logic FUNC_FRAME_END = 1'b1;

   typedef struct packed {
      logic               func;
      logic [COORD_W-1:0] rect_x;
      logic [COORD_W-1:0] rect_y;
      logic [COORD_W-1:0] rect_w;
      logic [COORD_W-1:0] rect_h;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_W-1:0] keep_x;
      logic [COORD_W-1:0] keep_y;
      logic [COORD_W-1:0] keep_w;
      logic [COORD_W-1:0] keep_h;
   } rsp_payload_type;

   typedef struct packed {
      logic [CTR_W-1:0] cx;
      logic [CTR_W-1:0] cy;
   } center_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      center_type        data;
   } mem_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic busy;
      logic hit_valid;
      logic hit;
   } dist_status_type;

   // position plus half the size, half truncated
   function automatic logic [CTR_W-1:0] center_of(input logic [COORD_W-1:0] pos,
                                                  input logic [COORD_W-1:0] size);
      center_of = {1'b0, pos} + {2'b00, size[COORD_W-1:1]};
   endfunction

endpackage

>>> design/gdf_center_store.sv
// Centre history memory: one row of MAX_RECTS centres per ring slot.
// One write port, one read port, registered read data. Depends on gdf_pkg.
module gdf_center_store (
   input  logic                 clock,
   input  gdf_pkg::mem_wr_type  wr,
   input  gdf_pkg::mem_rd_type  rd,
   output gdf_pkg::center_type  rd_data
);
   import gdf_pkg::*;

   center_type mem [2**ADDR_W];
   center_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/gdf_dist_pipe.sv
// Distance test pipeline: absolute differences, squares, sum and compare
// against the squared threshold, one stored centre per cycle. Depends on gdf_pkg.
module gdf_dist_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       issue,
   input  gdf_pkg::center_type        center,
   input  gdf_pkg::center_type        rd_data,
   input  logic [gdf_pkg::TSQ_W-1:0]  thresh_sq,
   output gdf_pkg::dist_status_type   status
);
   import gdf_pkg::*;

   logic             v0_ff, v1_ff, v2_ff, v3_ff;
   logic [CTR_W-1:0] dx_ff, dy_ff;
   logic [DSQ_W-1:0] sqx_ff, sqy_ff;
   logic             hit_ff;
   logic [SUM_W-1:0] dsum;

   assign dsum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= issue;   // memory data lands in the cycle after the read
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v0_ff) begin
         dx_ff <= (center.cx > rd_data.cx) ? center.cx - rd_data.cx : rd_data.cx - center.cx;
         dy_ff <= (center.cy > rd_data.cy) ? center.cy - rd_data.cy : rd_data.cy - center.cy;
      end
      if (v1_ff) begin
         sqx_ff <= dx_ff * dx_ff;
         sqy_ff <= dy_ff * dy_ff;
      end
      if (v2_ff) begin
         hit_ff <= dsum < SUM_W'(thresh_sq);
      end
   end

   assign status.busy      = v0_ff | v1_ff | v2_ff | v3_ff;
   assign status.hit_valid = v3_ff;
   assign status.hit       = hit_ff;

endmodule

>>> design/ghost_detection_filter_unit.sv
// Ghost detection filter. Rectangles of a frame arrive one per transaction,
// followed by an end-of-frame transaction; a rectangle whose centre lies closer
// than dist_thresh to at least min_hits centres of the previous window_frames-1
// frames is dropped, any other is passed on unchanged. End of frame gives no
// result. Once the window is warm the sequencer reads the centres stored in the
// previous back frames, where back is window_frames-1 (clamped), one stored
// centre per cycle from the single read port of the centre memory, stepping
// back one frame after each row, and then waits for the pipeline to drain.
// During warm-up, or with a window of one, no centres are read. The next
// transaction is taken once the result is in the output register or the
// rectangle is dropped, so a stalled result holds the input off. Depends on
// gdf_pkg, gdf_center_store and gdf_dist_pipe.
module ghost_detection_filter_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  gdf_pkg::req_payload_type           req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output gdf_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_wr_en,
   input  logic [gdf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gdf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import gdf_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   // configuration
   logic [THR_W-1:0]  dist_thresh_ff;
   logic [HITS_W-1:0] min_hits_ff;
   logic [WIN_W-1:0]  window_frames_ff;
   logic [TSQ_W-1:0]  thresh_sq_ff;

   // frame bookkeeping
   logic [CNT_W-1:0]  frame_counts_ff [HISTORY_FRAMES];
   logic [SLOT_W-1:0] write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0] frames_filled_ff, frames_filled_in;
   logic [CNT_W-1:0]  current_count_ff, current_count_in;

   // sequencer
   logic [1:0]        state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [MATCH_W-1:0] hits_ff, hits_in;
   logic              warm_ff, warm_in;
   center_type        center_ff;
   rsp_payload_type   rect_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_payload_ff;

   logic              req_take, frame_end, rect_take, drop, rsp_load;
   logic [SLOT_W-1:0] back;
   logic [SLOT_W-1:0] prev_write_slot;
   logic [CNT_W-1:0]  slot_count;
   center_type        new_center, rd_data;
   mem_wr_type        wr;
   mem_rd_type        rd;
   dist_status_type   dist_st;

   function automatic logic [SLOT_W-1:0] slot_before(input logic [SLOT_W-1:0] s);
      slot_before = (s == '0) ? SLOT_W'(HISTORY_FRAMES - 1) : s - SLOT_W'(1);
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign frame_end = req_take && (req_payload.func == FUNC_FRAME_END);
   assign rect_take = req_take && (req_payload.func == FUNC_RECT);

   // earlier frames to compare, window clamped to 1..HISTORY_FRAMES
   always_comb begin
      if (window_frames_ff == '0) begin
         back = '0;
      end else if (32'(window_frames_ff) > HISTORY_FRAMES) begin
         back = SLOT_W'(HISTORY_FRAMES - 1);
      end else begin
         back = SLOT_W'(window_frames_ff - WIN_W'(1));
      end
   end

   assign prev_write_slot = slot_before(write_slot_ff);
   assign slot_count      = frame_counts_ff[slot_ff];
   assign new_center.cx   = center_of(req_payload.rect_x, req_payload.rect_w);
   assign new_center.cy   = center_of(req_payload.rect_y, req_payload.rect_h);

   // every rectangle's centre is stored while the row has room
   assign wr.en   = rect_take && (current_count_ff < CNT_W'(MAX_RECTS));
   assign wr.addr = {write_slot_ff, current_count_ff[IDX_W-1:0]};
   assign wr.data = new_center;

   assign rd.en   = (state_ff == ST_SCAN) && (j_ff < slot_count);
   assign rd.addr = {slot_ff, j_ff[IDX_W-1:0]};

   assign drop     = warm_ff && (32'(hits_ff) >= 32'(min_hits_ff));
   assign rsp_load = (state_ff == ST_DONE) && !drop && (!rsp_valid_ff || !rsp_stall);

   gdf_center_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   gdf_dist_pipe u_dist (
      .clock     (clock),
      .reset     (reset),
      .issue     (rd.en),
      .center    (center_ff),
      .rd_data   (rd_data),
      .thresh_sq (thresh_sq_ff),
      .status    (dist_st)
   );

   always_comb begin
      state_in         = state_ff;
      slot_in          = slot_ff;
      rem_in           = rem_ff;
      j_in             = j_ff;
      hits_in          = hits_ff;
      warm_in          = warm_ff;
      write_slot_in    = write_slot_ff;
      frames_filled_in = frames_filled_ff;
      current_count_in = current_count_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;

      if (dist_st.hit_valid && dist_st.hit) begin
         hits_in = hits_ff + MATCH_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (frame_end) begin
               write_slot_in = (write_slot_ff == SLOT_W'(HISTORY_FRAMES - 1)) ?
                               '0 : write_slot_ff + SLOT_W'(1);
               if (frames_filled_ff < SLOT_W'(HISTORY_FRAMES - 1)) begin
                  frames_filled_in = frames_filled_ff + SLOT_W'(1);
               end
               current_count_in = '0;
            end else if (rect_take) begin
               warm_in = (frames_filled_ff >= back);
               slot_in = prev_write_slot;
               rem_in  = back;
               j_in    = '0;
               hits_in = '0;
               if (wr.en) begin
                  current_count_in = current_count_ff + CNT_W'(1);
               end
               state_in = ((frames_filled_ff >= back) && (back != '0)) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (j_ff < slot_count) begin
               j_in = j_ff + CNT_W'(1);
            end else begin
               // row finished: step back one frame
               j_in    = '0;
               slot_in = slot_before(slot_ff);
               rem_in  = rem_ff - SLOT_W'(1);
               if (rem_ff == SLOT_W'(1)) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!dist_st.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (drop) begin
               state_in = ST_IDLE;
            end else if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_thresh_ff   <= RST_DIST_THRESH;
         min_hits_ff      <= RST_MIN_HITS;
         window_frames_ff <= RST_WINDOW_FRAMES;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DIST_THRESH:   dist_thresh_ff   <= csr_wdata[THR_W-1:0];
            CSR_MIN_HITS:      min_hits_ff      <= csr_wdata[HITS_W-1:0];
            CSR_WINDOW_FRAMES: window_frames_ff <= csr_wdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      thresh_sq_ff <= dist_thresh_ff * dist_thresh_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_FRAMES; i++) begin
            frame_counts_ff[i] <= '0;
         end
      end else if (frame_end) begin
         frame_counts_ff[write_slot_ff] <= current_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         write_slot_ff    <= '0;
         frames_filled_ff <= '0;
         current_count_ff <= '0;
         rsp_valid_ff     <= 1'b0;
         slot_ff          <= '0;
         rem_ff           <= '0;
         j_ff             <= '0;
         hits_ff          <= '0;
         warm_ff          <= 1'b0;
      end else begin
         state_ff         <= state_in;
         write_slot_ff    <= write_slot_in;
         frames_filled_ff <= frames_filled_in;
         current_count_ff <= current_count_in;
         rsp_valid_ff     <= rsp_valid_in;
         slot_ff          <= slot_in;
         rem_ff           <= rem_in;
         j_ff             <= j_in;
         hits_ff          <= hits_in;
         warm_ff          <= warm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rect_take) begin
         center_ff      <= new_center;
         rect_ff.keep_x <= req_payload.rect_x;
         rect_ff.keep_y <= req_payload.rect_y;
         rect_ff.keep_w <= req_payload.rect_w;
         rect_ff.keep_h <= req_payload.rect_h;
      end
      if (rsp_load) begin
         rsp_payload_ff <= rect_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // the current frame's row is never read back while it is being filled
   a_rd_not_current: assert property (@(posedge clock) disable iff (reset)
      rd.en |-> (rd.addr[ADDR_W-1:IDX_W] != write_slot_ff))
      else $error("centre read hits the slot of the current frame");

   // a new result only appears when a rectangle finishes its match count
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the finishing state");

   // no distance test may be in flight once the sequencer is back at rest
   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !dist_st.busy)
      else $error("distance pipeline busy while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (current_count_ff <= CNT_W'(MAX_RECTS)))
      else $error("centre count of the frame overruns the row");

endmodule
